// File: src/line_segment_transform_macros.svh
// Assertion macros for the line segment transform block.
// Included by the RTL files that carry concurrent assertions.
`ifndef LINE_SEGMENT_TRANSFORM_MACROS_SVH
`define LINE_SEGMENT_TRANSFORM_MACROS_SVH
`ifndef SYNTH
`define LST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("line segment transform: same-cycle check failed");
`define LST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("line segment transform: next-cycle check failed");
`else
`define LST_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/lst_pkg.sv
// Shared types, constants and helper functions of the line segment transform.
// Depends on nothing; every other RTL file imports it.
`default_nettype none

package lst_pkg;

	localparam int COORD_BITS = 16;
	localparam int WIDE_BITS  = COORD_BITS + 20;
	localparam int ROT_FRAC   = 15;
	localparam int ROT_COS    = 32688;
	localparam int ROT_SIN    = 2286;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [WIDE_BITS-1:0]  wide_t;

	typedef enum logic [2:0] {
		MODE_LOAD    = 3'd0,
		MODE_GROW    = 3'd1,
		MODE_SHRINK  = 3'd2,
		MODE_ROT_CCW = 3'd3,
		MODE_ROT_CW  = 3'd4,
		MODE_MOVE    = 3'd5
	} mode_t;

	typedef struct packed {
		mode_t  mode;
		coord_t first_x;
		coord_t first_y;
		coord_t second_x;
		coord_t second_y;
		coord_t centre_x;
		coord_t centre_y;
	} cmd_t;

	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
	} seg_t;

	localparam wide_t ONE_W       = wide_t'(1);
	localparam wide_t ZERO_W      = wide_t'(0);
	localparam wide_t ROT_COS_W   = wide_t'(ROT_COS);
	localparam wide_t ROT_SIN_W   = wide_t'(ROT_SIN);
	localparam wide_t ROT_ROUND_W = wide_t'((64'd1 << ROT_FRAC) - 64'd1);
	localparam wide_t COORD_MAX_W = wide_t'((64'd1 << (COORD_BITS - 1)) - 64'd1);
	localparam wide_t COORD_MIN_W = -COORD_MAX_W - ONE_W;

	function automatic wide_t widen(input coord_t v);
		return wide_t'(v);
	endfunction

	function automatic coord_t sat(input wide_t v);
		coord_t r;
		if (v > COORD_MAX_W) begin
			r = coord_t'(COORD_MAX_W[COORD_BITS-1:0]);
		end else if (v < COORD_MIN_W) begin
			r = coord_t'(COORD_MIN_W[COORD_BITS-1:0]);
		end else begin
			r = coord_t'(v[COORD_BITS-1:0]);
		end
		return r;
	endfunction

	// Arithmetic shift right by the fraction bits, truncated toward zero.
	function automatic wide_t trunc_frac(input wide_t v);
		wide_t biased;
		biased = v + (v[WIDE_BITS-1] ? ROT_ROUND_W : ZERO_W);
		return biased >>> ROT_FRAC;
	endfunction

endpackage

`default_nettype wire

// File: src/lst_axis.sv
// One axis of the grow, shrink and move-centre commands.
// Depends on lst_pkg.
`default_nettype none

module lst_axis (
	input  lst_pkg::coord_t a,
	input  lst_pkg::coord_t b,
	input  lst_pkg::coord_t centre,
	input  logic            shrink,
	output lst_pkg::coord_t sc_a,
	output lst_pkg::coord_t sc_b,
	output lst_pkg::coord_t mv_a,
	output lst_pkg::coord_t mv_b
);
	import lst_pkg::*;

	wide_t aw;
	wide_t bw;
	wide_t cw;
	wide_t step;
	wide_t diff;
	wide_t half;
	logic  a_gt;

	assign aw   = widen(a);
	assign bw   = widen(b);
	assign cw   = widen(centre);
	assign a_gt = a > b;
	assign step = shrink ? -ONE_W : ONE_W;
	assign diff = aw - bw;
	assign half = (diff[WIDE_BITS-1] ? -diff : diff) >>> 1;

	assign sc_a = a_gt ? sat(aw + step) : sat(aw - step);
	assign sc_b = a_gt ? sat(bw - step) : sat(bw + step);
	assign mv_a = a_gt ? sat(cw + half) : sat(cw - half);
	assign mv_b = a_gt ? sat(cw - half) : sat(cw + half);

endmodule

`default_nettype wire

// File: src/lst_rotate.sv
// Rotates one endpoint by four degrees about a given midpoint, Q1.15 constants.
// Depends on lst_pkg.
`default_nettype none

module lst_rotate (
	input  lst_pkg::coord_t px,
	input  lst_pkg::coord_t py,
	input  lst_pkg::coord_t mx,
	input  lst_pkg::coord_t my,
	input  logic            ccw,
	output lst_pkg::coord_t rx,
	output lst_pkg::coord_t ry
);
	import lst_pkg::*;

	wide_t dx;
	wide_t dy;
	wide_t sin_dx;
	wide_t sin_dy;
	wide_t nx;
	wide_t ny;

	assign dx     = widen(px) - widen(mx);
	assign dy     = widen(py) - widen(my);
	assign sin_dx = ROT_SIN_W * dx;
	assign sin_dy = ROT_SIN_W * dy;

	assign nx = trunc_frac(ROT_COS_W * dx - (ccw ? sin_dy : -sin_dy));
	assign ny = trunc_frac((ccw ? sin_dx : -sin_dx) + ROT_COS_W * dy);

	assign rx = sat(nx + widen(mx));
	assign ry = sat(ny + widen(my));

endmodule

`default_nettype wire

// File: src/lst_next.sv
// Next endpoint values for one command, from the current segment.
// Depends on lst_pkg, lst_axis and lst_rotate.
`default_nettype none

module lst_next (
	input  lst_pkg::seg_t cur,
	input  lst_pkg::cmd_t cmd,
	output lst_pkg::seg_t nxt
);
	import lst_pkg::*;

	wide_t  sum_x;
	wide_t  sum_y;
	wide_t  mid_xw;
	wide_t  mid_yw;
	coord_t mid_x;
	coord_t mid_y;
	logic   shrink;
	logic   ccw;
	seg_t   scaled;
	seg_t   moved;
	seg_t   rotated;

	assign shrink = cmd.mode == MODE_SHRINK;
	assign ccw    = cmd.mode == MODE_ROT_CCW;

	// The midpoint is halved toward zero.
	assign sum_x  = widen(cur.ax) + widen(cur.bx);
	assign sum_y  = widen(cur.ay) + widen(cur.by);
	assign mid_xw = (sum_x + (sum_x[WIDE_BITS-1] ? ONE_W : ZERO_W)) >>> 1;
	assign mid_yw = (sum_y + (sum_y[WIDE_BITS-1] ? ONE_W : ZERO_W)) >>> 1;
	assign mid_x  = coord_t'(mid_xw[COORD_BITS-1:0]);
	assign mid_y  = coord_t'(mid_yw[COORD_BITS-1:0]);

	lst_axis u_axis_x (
		.a      (cur.ax),
		.b      (cur.bx),
		.centre (cmd.centre_x),
		.shrink (shrink),
		.sc_a   (scaled.ax),
		.sc_b   (scaled.bx),
		.mv_a   (moved.ax),
		.mv_b   (moved.bx)
	);

	lst_axis u_axis_y (
		.a      (cur.ay),
		.b      (cur.by),
		.centre (cmd.centre_y),
		.shrink (shrink),
		.sc_a   (scaled.ay),
		.sc_b   (scaled.by),
		.mv_a   (moved.ay),
		.mv_b   (moved.by)
	);

	lst_rotate u_rot_a (
		.px  (cur.ax),
		.py  (cur.ay),
		.mx  (mid_x),
		.my  (mid_y),
		.ccw (ccw),
		.rx  (rotated.ax),
		.ry  (rotated.ay)
	);

	lst_rotate u_rot_b (
		.px  (cur.bx),
		.py  (cur.by),
		.mx  (mid_x),
		.my  (mid_y),
		.ccw (ccw),
		.rx  (rotated.bx),
		.ry  (rotated.by)
	);

	always_comb begin
		case (cmd.mode)
			MODE_LOAD: begin
				nxt.ax = cmd.first_x;
				nxt.ay = cmd.first_y;
				nxt.bx = cmd.second_x;
				nxt.by = cmd.second_y;
			end
			MODE_GROW, MODE_SHRINK: begin
				nxt = scaled;
			end
			MODE_ROT_CCW, MODE_ROT_CW: begin
				nxt = rotated;
			end
			MODE_MOVE: begin
				nxt = moved;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: src/line_segment_transform.sv
// Top level of the line segment transform: command register, endpoint registers.
// Depends on lst_pkg, lst_next and the assertion macro header.
//
//  channel  handshake             payload
//  input    in_valid / in_ready   mode, first_x/y, second_x/y, centre_x/y
//  output   out_valid / out_ready out_first_x/y, out_second_x/y
//
// A command word is registered, then updates the endpoint registers when it advances.
// One word per cycle is sustained while out_ready stays high.
// The endpoint registers are the output register and reset to zero.
// While an output word waits, one further input word is held in the command register.
`default_nettype none
`include "line_segment_transform_macros.svh"

module line_segment_transform (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [2:0]      mode,
	input  lst_pkg::coord_t first_x,
	input  lst_pkg::coord_t first_y,
	input  lst_pkg::coord_t second_x,
	input  lst_pkg::coord_t second_y,
	input  lst_pkg::coord_t centre_x,
	input  lst_pkg::coord_t centre_y,
	output logic            out_valid,
	input  logic            out_ready,
	output lst_pkg::coord_t out_first_x,
	output lst_pkg::coord_t out_first_y,
	output lst_pkg::coord_t out_second_x,
	output lst_pkg::coord_t out_second_y
);
	import lst_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	seg_t seg_q;
	seg_t seg_next;
	logic out_valid_q;
	logic advance;
	logic in_take;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1.mode     <= mode_t'(mode);
			cmd_s1.first_x  <= first_x;
			cmd_s1.first_y  <= first_y;
			cmd_s1.second_x <= second_x;
			cmd_s1.second_y <= second_y;
			cmd_s1.centre_x <= centre_x;
			cmd_s1.centre_y <= centre_y;
		end
	end

	lst_next u_next (
		.cur (seg_q),
		.cmd (cmd_s1),
		.nxt (seg_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				seg_q       <= seg_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_first_x  = seg_q.ax;
	assign out_first_y  = seg_q.ay;
	assign out_second_x = seg_q.bx;
	assign out_second_y = seg_q.by;

	`LST_ASSERT_NEXT(a_adv_gives_word, clk, arst_n, advance, out_valid_q)
	`LST_ASSERT_NEXT(a_hold_while_stalled, clk, arst_n, out_valid_q && !out_ready, $stable(seg_q))
	`LST_ASSERT_NEXT(a_load_first_x, clk, arst_n, advance && cmd_s1.mode == MODE_LOAD, seg_q.ax == $past(cmd_s1.first_x))
	`LST_ASSERT_SAME(a_stall_only_when_full, clk, arst_n, valid_s1 && out_valid_q && !out_ready, !in_ready && !advance)

endmodule

`default_nettype wire
